[sv/i2p_pkg.sv]
// Shared types, operator codes and precedence tables of the infix-to-postfix converter.
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_LPAR = 3'd5;
  localparam logic [2:0] OP_RPAR = 3'd6;
  localparam logic [2:0] OP_NONE = 3'd7;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic KIND_CHAR     = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic pop;
    logic push;
    logic emit_operand;
    logic emit_pop;
    logic emit_ovf;
    logic flush;
  } i2p_cmd_t;

  typedef struct packed {
    logic new_operand;
    logic is_end;
    logic count_zero;
    logic full;
    logic prec_gt;
    logic prec_eq;
    logic pend_valid;
    logic out_free;
  } i2p_status_t;

  function automatic logic [2:0] classify(input logic [7:0] c);
    logic [2:0] code;
    code = OP_NONE;
    unique case (c)
      8'h2B: code = OP_ADD;
      8'h2D: code = OP_SUB;
      8'h2A: code = OP_MUL;
      8'h2F: code = OP_DIV;
      8'h5E: code = OP_POW;
      8'h28: code = OP_LPAR;
      8'h29: code = OP_RPAR;
      default: code = OP_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] code);
    logic [7:0] c;
    c = 8'h2B;
    unique case (code)
      OP_ADD:  c = 8'h2B;
      OP_SUB:  c = 8'h2D;
      OP_MUL:  c = 8'h2A;
      OP_DIV:  c = 8'h2F;
      OP_POW:  c = 8'h5E;
      OP_LPAR: c = 8'h28;
      OP_RPAR: c = 8'h29;
      default: c = 8'h2B;
    endcase
    return c;
  endfunction

  // Precedences are offset by one so that the empty stack ranks as zero.
  function automatic logic [3:0] prec_incoming(input logic [2:0] code);
    logic [3:0] p;
    p = 4'd0;
    unique case (code)
      OP_ADD, OP_SUB: p = 4'd2;
      OP_MUL, OP_DIV: p = 4'd4;
      OP_POW:         p = 4'd7;
      OP_LPAR:        p = 4'd8;
      OP_RPAR:        p = 4'd1;
      default:        p = 4'd0;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] prec_stacked(input logic [2:0] code);
    logic [3:0] p;
    p = 4'd0;
    unique case (code)
      OP_ADD, OP_SUB: p = 4'd3;
      OP_MUL, OP_DIV: p = 4'd5;
      OP_POW:         p = 4'd6;
      OP_LPAR:        p = 4'd1;
      OP_RPAR:        p = 4'd0;
      default:        p = 4'd0;
    endcase
    return p;
  endfunction

endpackage

[sv/infix_to_postfix_converter.sv]
// Top level of the infix-to-postfix converter: controller, datapath and checks.
// The block takes one expression character or end marker per input beat and returns
// postfix characters as output beats, with tlast on the final beat that an input causes
// and tuser set on the single beat that reports a dropped operator on a full stack.
// An operand goes from IDLE straight to FINISH; an operator or end marker stays in DECIDE
// while operators are popped, since every stack compare waits on the registered read
// of the stack RAM and each emitting pop reads the next entry in the same cycle. A result
// beat waits in a one-entry holding register until the next one is known, so it can
// carry tlast; the output register lets the next beat be prepared while one is stalled.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       s_tuser,   // [0] action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tuser,   // [0] kind
  output logic       m_tlast
);

  i2p_pkg::i2p_cmd_t    cmd;
  i2p_pkg::i2p_status_t status;

  i2p_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  i2p_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .status  (status)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !status.full)
    else $error("push issued on a full operator stack");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !status.count_zero)
    else $error("pop issued on an empty operator stack");

  a_one_result_move: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_operand, cmd.emit_pop, cmd.emit_ovf, cmd.flush}))
    else $error("more than one result source in a cycle");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'h00))
    else $error("overflow beat carries a nonzero character");

endmodule

[sv/i2p_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module i2p_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/i2p_ctrl.sv]
// Controller state machine that sequences accept, stack compare, pops and result flushing.
module i2p_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  i2p_pkg::i2p_status_t status,
  output i2p_pkg::i2p_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECIDE = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   can_emit;

  assign can_emit = !status.pend_valid || status.out_free;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (status.new_operand) begin
            cmd.emit_operand = 1'b1;
            state_next       = ST_FINISH;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (status.is_end) begin
          if (status.count_zero) begin
            state_next = ST_FINISH;
          end else if (can_emit) begin
            cmd.emit_pop = 1'b1;
            cmd.pop      = 1'b1;
            cmd.rd_en    = 1'b1;
          end
        end else if (status.prec_gt) begin
          if (status.full) begin
            if (can_emit) begin
              cmd.emit_ovf = 1'b1;
              state_next   = ST_FINISH;
            end
          end else begin
            cmd.push   = 1'b1;
            state_next = ST_FINISH;
          end
        end else if (status.prec_eq) begin
          cmd.pop    = 1'b1;
          state_next = ST_FINISH;
        end else if (can_emit) begin
          cmd.emit_pop = 1'b1;
          cmd.pop      = 1'b1;
          cmd.rd_en    = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!status.pend_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/i2p_dp.sv]
// Datapath: operator stack, precedence compare, pending result and output register.
module i2p_dp #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           s_tdata,
  input  logic                 s_tuser,
  output logic [7:0]           m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  i2p_pkg::i2p_cmd_t    cmd,
  output i2p_pkg::i2p_status_t status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic          act;
  logic [2:0]    code;
  logic [CW-1:0] count;
  logic [2:0]    rdata;
  logic [CW-1:0] rd_count;
  logic [AW-1:0] raddr;
  logic [3:0]    top_prec;
  logic [3:0]    in_prec;
  logic          pend_valid;
  logic [7:0]    pend_char;
  logic          pend_kind;
  logic [7:0]    new_char;
  logic          new_emit;
  logic          out_free;

  assign rd_count = cmd.pop ? (count - CW'(2)) : (count - CW'(1));
  assign raddr    = rd_count[AW-1:0];

  i2p_ram #(
    .WIDTH(3),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(count[AW-1:0]),
    .wdata(code),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign top_prec = (count == '0) ? 4'd0 : i2p_pkg::prec_stacked(rdata);
  assign in_prec  = i2p_pkg::prec_incoming(code);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    status             = '0;
    status.new_operand = (s_tuser == i2p_pkg::ACT_CHAR) &&
                         (i2p_pkg::classify(s_tdata) == i2p_pkg::OP_NONE);
    status.is_end      = (act == i2p_pkg::ACT_END);
    status.count_zero  = (count == '0);
    status.full        = (count == FULL_COUNT);
    status.prec_gt     = in_prec > top_prec;
    status.prec_eq     = in_prec == top_prec;
    status.pend_valid  = pend_valid;
    status.out_free    = out_free;
  end

  assign new_emit = cmd.emit_operand || cmd.emit_pop || cmd.emit_ovf;

  always_comb begin
    priority if (cmd.emit_operand) begin
      new_char = s_tdata;
    end else if (cmd.emit_pop) begin
      new_char = i2p_pkg::op_char(rdata);
    end else begin
      new_char = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= s_tuser;
      code <= i2p_pkg::classify(s_tdata);
    end
    if (new_emit) begin
      pend_char <= new_char;
      pend_kind <= cmd.emit_ovf ? i2p_pkg::KIND_OVERFLOW : i2p_pkg::KIND_CHAR;
    end
    if ((new_emit && pend_valid) || cmd.flush) begin
      m_tdata <= pend_char;
      m_tuser <= pend_kind;
      m_tlast <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count - CW'(1);
      end
      if (new_emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((new_emit && pend_valid) || cmd.flush) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
